// File: rtl/fgb_pkg.sv
// Package for the 2bpp glyph blitter: shared constants, codes and types.
// Used by fgb_front, fgb_back and the top level; depends on nothing.
package fgb_pkg;

    localparam int BUFFER_BYTES = 32768;
    localparam int GLYPH_ROWS   = 18;
    localparam int FONT_CHARS   = 256;
    localparam int ROW_BYTES    = 3;
    localparam int GLYPH_BYTES  = GLYPH_ROWS * ROW_BYTES;
    localparam int FONT_BYTES   = FONT_CHARS * GLYPH_BYTES;
    localparam int FONT_AW      = 14;
    localparam int FB_AW        = 17;
    localparam int ROW_W        = 5;
    localparam int GLYPH_PIX    = 12;

    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = 2;

    localparam int S_DATA_W = 56;
    localparam int M_DATA_W = 88;

    // opcodes on s_tuser
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_DRAW = 1'b1;

    // configuration register indexes
    localparam logic [1:0] CFG_LINE_BYTES = 2'd0;
    localparam logic [1:0] CFG_BLACK_CODE = 2'd1;
    localparam logic [1:0] CFG_WHITE_CODE = 2'd2;

    // font pixel codes that are drawn
    localparam logic [1:0] CODE_BLACK = 2'b00;
    localparam logic [1:0] CODE_WHITE = 2'b10;

    localparam logic [7:0] LINE_BYTES_RST = 8'd90;
    localparam logic [1:0] BLACK_CODE_RST = 2'd0;
    localparam logic [1:0] WHITE_CODE_RST = 2'd1;

    typedef enum logic [1:0] {
        KIND_NOP  = 2'd0,
        KIND_LOAD = 2'd1,
        KIND_DRAW = 2'd2
    } kind_t;

    typedef struct packed {
        logic [7:0] line_bytes;
        logic [1:0] black_code;
        logic [1:0] white_code;
    } cfg_t;

    typedef struct packed {
        kind_t              kind;
        logic [FONT_AW-1:0] font_address;
        logic [7:0]         font_byte;
        logic               buffer_index;
        logic [9:0]         pos_x;
        logic [8:0]         pos_y;
        logic [7:0]         char_index;
    } q_item_t;

    typedef struct packed {
        logic [FB_AW-1:0] write_address;
        logic [31:0]      write_data;
        logic [31:0]      write_mask;
        logic [ROW_W-1:0] glyph_row;
        logic             last;
    } wr_item_t;

endpackage

// File: rtl/fgb_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module fgb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/fgb_front.sv
// Front end: accepts input transfers, classifies them and queues them.
// Depends on fgb_pkg.
module fgb_front (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    // font_address[13:0], font_byte[21:14], buffer_index[22], pos_x[32:23],
    // pos_y[41:33], char_index[49:42], zero fill above
    input  logic [fgb_pkg::S_DATA_W-1:0] s_tdata,
    // opcode[0]
    input  logic [0:0]               s_tuser,
    output logic                     q_valid,
    input  logic                     q_pop,
    output fgb_pkg::q_item_t         q_item
);

    fgb_pkg::q_item_t           in_item;
    fgb_pkg::q_item_t           mem_reg [fgb_pkg::Q_DEPTH];
    logic [fgb_pkg::Q_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [fgb_pkg::Q_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [fgb_pkg::Q_AW:0]     count_reg, count_next;
    logic                       push, pop;

    always_comb begin
        in_item.font_address = s_tdata[13:0];
        in_item.font_byte    = s_tdata[21:14];
        in_item.buffer_index = s_tdata[22];
        in_item.pos_x        = s_tdata[32:23];
        in_item.pos_y        = s_tdata[41:33];
        in_item.char_index   = s_tdata[49:42];
        if (s_tuser[0] == fgb_pkg::OP_DRAW) begin
            in_item.kind = fgb_pkg::KIND_DRAW;
        end else if (32'(s_tdata[13:0]) < fgb_pkg::FONT_BYTES) begin
            in_item.kind = fgb_pkg::KIND_LOAD;
        end else begin
            in_item.kind = fgb_pkg::KIND_NOP;
        end
    end

    assign s_tready = (count_reg != (fgb_pkg::Q_AW+1)'(fgb_pkg::Q_DEPTH));
    assign q_valid  = (count_reg != '0);
    assign q_item   = mem_reg[rd_ptr_reg];
    assign push     = s_tvalid && s_tready;
    assign pop      = q_pop && q_valid;

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

// File: rtl/fgb_back.sv
// Back end: executes queued items, owns the font store and renders glyph rows
// into the output register. Depends on fgb_pkg and fgb_ram.
module fgb_back (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  fgb_pkg::cfg_t        cfg,
    input  logic                 q_valid,
    output logic                 q_pop,
    input  fgb_pkg::q_item_t     q_item,
    output logic                 out_valid,
    input  logic                 out_ready,
    output fgb_pkg::wr_item_t    out_item
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_READ = 3'b010,
        ST_EMIT = 3'b100
    } state_t;

    state_t                       state_reg, state_next;
    logic [1:0]                   cnt_reg, cnt_next;
    logic [fgb_pkg::ROW_W-1:0]    row_reg, row_next;
    logic [fgb_pkg::FONT_AW-1:0]  font_addr_reg, font_addr_next;
    logic [fgb_pkg::FB_AW-1:0]    fb_addr_reg, fb_addr_next;
    logic [1:0]                   sub_reg, sub_next;
    logic [23:0]                  row_bits_reg, row_bits_next;
    logic                         out_valid_reg, out_valid_next;
    fgb_pkg::wr_item_t            out_item_reg, out_item_next;

    logic                         ram_we, ram_re, load_ok;
    logic [7:0]                   ram_rdata;
    logic [31:0]                  pix_data, pix_mask;
    logic [fgb_pkg::FB_AW-1:0]    start_addr;
    logic [fgb_pkg::FB_AW-1:0]    line_prod;
    logic [fgb_pkg::FONT_AW-1:0]  glyph_base;

    fgb_ram #(
        .WIDTH (8),
        .DEPTH (fgb_pkg::FONT_BYTES)
    ) u_font_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (q_item.font_address),
        .wr_data (q_item.font_byte),
        .rd_en   (ram_re),
        .rd_addr (font_addr_reg),
        .rd_data (ram_rdata)
    );

    assign load_ok    = !out_valid_reg || out_ready;
    assign q_pop      = (state_reg == ST_IDLE) && q_valid;
    assign ram_we     = q_pop && (q_item.kind == fgb_pkg::KIND_LOAD);
    assign ram_re     = (state_reg == ST_READ) && (cnt_reg != 2'd3);
    assign line_prod  = fgb_pkg::FB_AW'(q_item.pos_y) * fgb_pkg::FB_AW'(cfg.line_bytes);
    assign glyph_base = fgb_pkg::FONT_AW'(q_item.char_index)
                      * fgb_pkg::FONT_AW'(fgb_pkg::GLYPH_BYTES);
    assign start_addr = (q_item.buffer_index ? fgb_pkg::FB_AW'(fgb_pkg::BUFFER_BYTES)
                                             : fgb_pkg::FB_AW'(0))
                      + line_prod + fgb_pkg::FB_AW'(q_item.pos_x[9:2]);

    // place 12 font pixels into four framebuffer bytes after the sub-byte offset
    always_comb begin
        logic [1:0] code_v;
        logic [3:0] q_v;
        logic [4:0] bit_v;
        pix_data = '0;
        pix_mask = '0;
        for (int i = 0; i < fgb_pkg::GLYPH_PIX; i++) begin
            code_v = row_bits_reg[23-2*i -: 2];
            q_v    = 4'(sub_reg) + 4'(i);
            bit_v  = {q_v[3:2], 3'b000} + {2'b00, ~q_v[1:0], 1'b0};
            if (code_v == fgb_pkg::CODE_BLACK) begin
                pix_data[bit_v +: 2] = cfg.black_code;
                pix_mask[bit_v +: 2] = 2'b11;
            end else if (code_v == fgb_pkg::CODE_WHITE) begin
                pix_data[bit_v +: 2] = cfg.white_code;
                pix_mask[bit_v +: 2] = 2'b11;
            end
        end
    end

    always_comb begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        row_next       = row_reg;
        font_addr_next = font_addr_reg;
        fb_addr_next   = fb_addr_reg;
        sub_next       = sub_reg;
        row_bits_next  = row_bits_reg;
        out_item_next  = out_item_reg;
        out_valid_next = out_valid_reg;
        if (out_ready) begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE: begin
                if (q_valid && (q_item.kind == fgb_pkg::KIND_DRAW)) begin
                    font_addr_next = glyph_base;
                    fb_addr_next   = start_addr;
                    sub_next       = q_item.pos_x[1:0];
                    row_next       = '0;
                    cnt_next       = '0;
                    state_next     = ST_READ;
                end
            end
            ST_READ: begin
                if (ram_re) begin
                    font_addr_next = font_addr_reg + 1'b1;
                end
                if (cnt_reg != 2'd0) begin
                    row_bits_next = {row_bits_reg[15:0], ram_rdata};
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == 2'd3) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (load_ok) begin
                    out_valid_next              = 1'b1;
                    out_item_next.write_address = fb_addr_reg;
                    out_item_next.write_data    = pix_data;
                    out_item_next.write_mask    = pix_mask;
                    out_item_next.glyph_row     = row_reg;
                    out_item_next.last          =
                        (row_reg == fgb_pkg::ROW_W'(fgb_pkg::GLYPH_ROWS - 1));
                    fb_addr_next = fb_addr_reg + fgb_pkg::FB_AW'(cfg.line_bytes);
                    row_next     = row_reg + 1'b1;
                    cnt_next     = '0;
                    if (row_reg == fgb_pkg::ROW_W'(fgb_pkg::GLYPH_ROWS - 1)) begin
                        state_next = ST_IDLE;
                    end else begin
                        state_next = ST_READ;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            row_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            row_reg       <= row_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        font_addr_reg <= font_addr_next;
        fb_addr_reg   <= fb_addr_next;
        sub_reg       <= sub_next;
        row_bits_reg  <= row_bits_next;
        out_item_reg  <= out_item_next;
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

// File: rtl/font_glyph_blitter_2bpp.sv
// Top level of the 12x18 2bpp glyph blitter: configuration registers, front
// queue and render back end. Depends on fgb_pkg, fgb_front and fgb_back.
//
// A load transfer writes one font byte when the back end takes it from the
// queue. A draw transfer yields 18 masked framebuffer writes, one per glyph
// row. For each row the back end issues three reads on the font RAM's one
// read port, waits for the last byte to land and then assembles the row;
// assembly waits while the result side stalls. A four-entry queue takes new
// items while the back end works, and an output register holds a finished
// write while the next row is read. Font entries are undefined until loaded.
module font_glyph_blitter_2bpp (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // font_address[13:0], font_byte[21:14], buffer_index[22], pos_x[32:23],
    // pos_y[41:33], char_index[49:42], zero fill above
    input  logic [fgb_pkg::S_DATA_W-1:0] s_tdata,
    // opcode[0]
    input  logic [0:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // write_address[16:0], write_data[48:17], write_mask[80:49],
    // glyph_row[85:81], zero fill above
    output logic [fgb_pkg::M_DATA_W-1:0] m_tdata,
    output logic        m_tlast,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_wdata
);

    fgb_pkg::cfg_t      cfg_reg, cfg_next;
    fgb_pkg::q_item_t   q_item;
    fgb_pkg::wr_item_t  out_item;
    logic               q_valid, q_pop;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                fgb_pkg::CFG_LINE_BYTES: cfg_next.line_bytes = cfg_wdata;
                fgb_pkg::CFG_BLACK_CODE: cfg_next.black_code = cfg_wdata[1:0];
                fgb_pkg::CFG_WHITE_CODE: cfg_next.white_code = cfg_wdata[1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.line_bytes <= fgb_pkg::LINE_BYTES_RST;
            cfg_reg.black_code <= fgb_pkg::BLACK_CODE_RST;
            cfg_reg.white_code <= fgb_pkg::WHITE_CODE_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    fgb_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_valid  (q_valid),
        .q_pop    (q_pop),
        .q_item   (q_item)
    );

    fgb_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .q_valid   (q_valid),
        .q_pop     (q_pop),
        .q_item    (q_item),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_item  (out_item)
    );

    assign m_tdata = {2'b00, out_item.glyph_row, out_item.write_mask,
                      out_item.write_data, out_item.write_address};
    assign m_tlast = out_item.last;

    a_last_row: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tlast == (m_tdata[85:81] == 5'(fgb_pkg::GLYPH_ROWS - 1))))
        else $error("tlast does not match final glyph row");

    a_data_masked: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ((m_tdata[48:17] & ~m_tdata[80:49]) == 32'd0))
        else $error("write data set outside write mask");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

endmodule
